### rtl/tvg_pkg.sv
`timescale 1ns / 1ps

package tvg_pkg;

  typedef enum logic [2:0] {
    MODE_RESET    = 3'd0,
    MODE_PEN_UP   = 3'd1,
    MODE_PEN_DOWN = 3'd2,
    MODE_TURN     = 3'd3,
    MODE_MOVE     = 3'd4
  } tvg_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_CORDIC,
    ST_MUL_C,
    ST_MUL_S,
    ST_DONE
  } tvg_state_t;

  typedef enum logic [1:0] {
    AP_IDLE,
    AP_MOD,
    AP_HI,
    AP_LO
  } tvg_ang_phase_t;

  typedef enum logic {
    CP_IDLE,
    CP_RUN
  } tvg_cor_phase_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } tvg_vec_t;

  localparam int ATAN_LEN = 30;

  // atan(2^-i) as binary angles, full turn = 2^32
  localparam logic [31:0] ATAN_BAM [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  localparam logic signed [31:0] INV_GAIN_Q30 = 32'sh26DD3B6A;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sh07FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -35'sh080000000) begin
      r = -32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // (p + 2^29) >>> 30, flooring
  function automatic logic signed [33:0] round_q30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sh20000000;
    return t[63:30];
  endfunction

endpackage

### rtl/tvg_angle.sv
`timescale 1ns / 1ps

module tvg_angle import tvg_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] heading,
  output logic               done,
  output logic        [31:0] bam
);

  localparam int UP_SHIFT = FRAC_BITS + 3;
  localparam int LOW_PAD  = 29 - FRAC_BITS;
  localparam logic [21:0] K_BIAS   = 22'd1474560;
  localparam logic [22:0] RECIP_45 = 23'd5965233;

  tvg_ang_phase_t phase, phase_next;

  logic [21:0] num;
  logic [31:0] frac;
  logic [15:0] q_hi;
  logic [44:0] mprod;
  logic [16:0] quo;
  logic [21:0] qx45;
  logic [21:0] rdiff;
  logic [5:0]  rmd;

  // num / 45 by reciprocal multiply, exact for num below 2^22
  assign mprod = 45'(num) * 45'(RECIP_45);
  assign quo   = mprod[44:28];
  assign qx45  = 22'(quo) * 22'd45;
  assign rdiff = num - qx45;
  assign rmd   = rdiff[5:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= AP_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      AP_IDLE: if (start) phase_next = AP_MOD;
      AP_MOD:  phase_next = AP_HI;
      AP_HI:   phase_next = AP_LO;
      AP_LO:   phase_next = AP_IDLE;
      default: phase_next = AP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (phase == AP_LO);
    end
  end

  // heading = k * 2^(FRAC_BITS+3) + low, full turn = 45 * 2^(FRAC_BITS+3)
  // k mod 45, then two 16-bit digits of ((k mod 45) * 2^32 + low shifted up) / 45
  always_ff @(posedge clk) begin
    unique case (phase)
      AP_IDLE: begin
        if (start) begin
          num  <= 22'(heading >>> UP_SHIFT) + K_BIAS;
          frac <= {heading[UP_SHIFT-1:0], {LOW_PAD{1'b0}}};
        end
      end
      AP_MOD: begin
        num <= {rmd, frac[31:16]};
      end
      AP_HI: begin
        q_hi <= quo[15:0];
        num  <= {rmd, frac[15:0]};
      end
      AP_LO: begin
        bam <= {q_hi, quo[15:0]};
      end
      default: ;
    endcase
  end

endmodule

### rtl/tvg_cordic.sv
`timescale 1ns / 1ps

module tvg_cordic import tvg_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] bam,
  output logic        done,
  output tvg_vec_t    vec
);

  localparam int SW = $clog2(CORDIC_STEPS);

  tvg_cor_phase_t phase, phase_next;

  logic signed [31:0] x, y, z;
  logic               flip;
  logic [SW-1:0]      step;
  logic               last;
  logic               rot;
  logic signed [31:0] sx, sy, atan_i;
  logic signed [31:0] nx, ny, nz;

  assign last   = step == SW'(CORDIC_STEPS - 1);
  assign rot    = !z[31];
  assign sx     = x >>> step;
  assign sy     = y >>> step;
  assign atan_i = $signed(ATAN_BAM[5'(step)]);
  assign nx     = rot ? x - sy : x + sy;
  assign ny     = rot ? y + sx : y - sx;
  assign nz     = rot ? z - atan_i : z + atan_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= CP_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      CP_IDLE: if (start) phase_next = CP_RUN;
      CP_RUN:  if (last) phase_next = CP_IDLE;
      default: phase_next = CP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (phase == CP_RUN) && last;
    end
  end

  always_ff @(posedge clk) begin
    if (phase == CP_IDLE) begin
      if (start) begin
        // left half plane folds by half a turn
        flip <= bam[31] ^ bam[30];
        z    <= $signed({bam[30], bam[30:0]});
        x    <= INV_GAIN_Q30;
        y    <= '0;
        step <= '0;
      end
    end else begin
      x    <= nx;
      y    <= ny;
      z    <= nz;
      step <= step + SW'(1);
      if (last) begin
        vec.x <= flip ? -nx : nx;
        vec.y <= flip ? -ny : ny;
      end
    end
  end

endmodule

### rtl/turtle_vector_generator.sv
`timescale 1ns / 1ps

// channel  dir  tdata                                   tuser
// s_*      in   amount[31:0]                            mode[2:0]
// m_*      out  heading_deg, pos_x, pos_y, from_x,      pen_was_down, draw_segment,
//               from_y (32 bits each, lowest first)     clear_screen
//
// one command at a time; s_tready is high only while idle
// reset, pen and turn commands go from ST_IDLE straight to ST_DONE; m_tvalid rises once the output register is free
// move: ST_ANGLE (three passes through the shared reciprocal divide for the heading), ST_CORDIC
//   (the CORDIC iterations) and the two multiply states ST_MUL_C and ST_MUL_S, then ST_DONE
// rst is synchronous; afterwards position and heading are zero and the pen is down
// a stalled result sits in the output register; the next command is taken meanwhile

module turtle_vector_generator import tvg_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // amount
  input  logic [2:0]   s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,   // heading_deg, pos_x, pos_y, from_x, from_y
  output logic [2:0]   m_tuser    // pen_was_down, draw_segment, clear_screen
);

  tvg_state_t state, state_next;

  logic [2:0]         mode_q;
  logic signed [31:0] amount_q;
  logic signed [31:0] cur_x, cur_y, heading;
  logic               pen_down;
  logic signed [63:0] prod;
  logic signed [31:0] new_x;
  logic signed [31:0] mul_b;

  logic     accept;
  logic     out_free;
  logic     angle_start;
  logic     angle_done;
  logic     cordic_done;
  logic     [31:0] bam;
  tvg_vec_t vec;

  logic               was, draw, clr, pen_nx;
  logic signed [31:0] hd, px, py, fx, fy;

  assign accept      = s_tvalid && s_tready;
  assign out_free    = !m_tvalid || m_tready;
  assign angle_start = accept && (s_tuser == MODE_MOVE);
  assign mul_b       = (state == ST_MUL_C) ? vec.x : vec.y;

  tvg_angle #(
    .FRAC_BITS(FRAC_BITS)
  ) u_angle (
    .clk     (clk),
    .rst     (rst),
    .start   (angle_start),
    .heading (heading),
    .done    (angle_done),
    .bam     (bam)
  );

  tvg_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (angle_done),
    .bam   (bam),
    .done  (cordic_done),
    .vec   (vec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (s_tuser == MODE_MOVE) ? ST_ANGLE : ST_DONE;
        end
      end
      ST_ANGLE:  if (angle_done) state_next = ST_CORDIC;
      ST_CORDIC: if (cordic_done) state_next = ST_MUL_C;
      ST_MUL_C:  state_next = ST_MUL_S;
      ST_MUL_S:  state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    was    = 1'b0;
    draw   = 1'b0;
    clr    = 1'b0;
    fx     = '0;
    fy     = '0;
    hd     = heading;
    px     = cur_x;
    py     = cur_y;
    pen_nx = pen_down;
    case (mode_q)
      MODE_RESET: begin
        hd     = '0;
        px     = '0;
        py     = '0;
        pen_nx = 1'b1;
        clr    = 1'b1;
      end
      MODE_PEN_UP: begin
        was    = pen_down;
        pen_nx = 1'b0;
      end
      MODE_PEN_DOWN: begin
        was    = pen_down;
        pen_nx = 1'b1;
      end
      MODE_TURN: begin
        hd = sat32(35'(heading) + 35'(amount_q));
      end
      MODE_MOVE: begin
        fx   = cur_x;
        fy   = cur_y;
        draw = pen_down;
        px   = new_x;
        py   = sat32(35'(cur_y) + 35'(round_q30(prod)));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= s_tuser;
      amount_q <= s_tdata;
    end
    if (state == ST_MUL_C || state == ST_MUL_S) begin
      prod <= amount_q * mul_b;
    end
    if (state == ST_MUL_S) begin
      new_x <= sat32(35'(cur_x) + 35'(round_q30(prod)));
    end
    if (state == ST_DONE && out_free) begin
      m_tdata <= {fy, fx, py, px, hd};
      m_tuser <= {clr, draw, was};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x    <= '0;
      cur_y    <= '0;
      heading  <= '0;
      pen_down <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_DONE && out_free) begin
        cur_x    <= px;
        cur_y    <= py;
        heading  <= hd;
        pen_down <= pen_nx;
        m_tvalid <= 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_angle_done_in_angle: assert property (@(posedge clk) disable iff (rst)
    angle_done |-> state == ST_ANGLE)
    else $error("angle unit finished outside its wait state");

  a_cordic_done_in_cordic: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> state == ST_CORDIC)
    else $error("cordic finished outside its wait state");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second command taken while one is in flight");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> (m_tdata == '0 && m_tuser[1:0] == 2'b00))
    else $error("clear result carries nonzero fields");
`endif

endmodule
